/* hdl/ngfe_pkg.sv */
// Shared types and constants for the NMEA GGA fix extractor.
// No dependencies; every other file in hdl/ refers to it by scoped names.

package ngfe_pkg;

    // Sentence kinds, as reported on the result channel
    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GGA   = 3'd1,
        KIND_GSA   = 3'd2,
        KIND_GSV   = 3'd3,
        KIND_RMC   = 3'd4,
        KIND_VTG   = 3'd5
    } kind_t;

    // Status of a fix
    typedef enum logic [1:0] {
        FIX_VALID     = 2'd0,
        FIX_PARSE_ERR = 2'd1,
        FIX_NONE      = 2'd2
    } fix_status_t;

    // One decoded fix; positions in 1/600000 degree, two's complement
    typedef struct packed {
        fix_status_t        status;
        logic [6:0]         hour;
        logic [6:0]         minute;
        logic [6:0]         second;
        logic [19:0]        tih;
        logic signed [26:0] lat;
        logic signed [30:0] lon;
    } fix_t;

    localparam fix_t FIX_EMPTY = '{status: FIX_NONE, default: '0};

    // Per-character control from the framing logic (already qualified by the transfer)
    typedef struct packed {
        logic       start;   // sixth character completed a $GPGGA prefix
        logic       parse;   // GGA body character to decode
        logic       star;    // end of sentence
        kind_t      kind;    // sentence kind, valid with star
        logic [6:0] length;  // characters stored including '*', valid with star
    } frame_ctl_t;

    // Characters of interest
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SOUTH = 8'h53;
    localparam logic [7:0] CHAR_WEST  = 8'h57;

    // Sentence prefixes, one per kind from GGA upward
    localparam int PREFIX_LEN = 6;
    localparam int KIND_NUM   = 5;
    localparam logic [47:0] KIND_TEXT [KIND_NUM] = '{
        "$GPGGA", "$GPGSA", "$GPGSV", "$GPRMC", "$GPVTG"
    };

    // Character at a position of a six-character prefix (first character in the MSBs)
    function automatic logic [7:0] kind_char(input logic [47:0] text, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = text[47:40];
            3'd1:    ch = text[39:32];
            3'd2:    ch = text[31:24];
            3'd3:    ch = text[23:16];
            3'd4:    ch = text[15:8];
            3'd5:    ch = text[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hdl/ngfe_frame.sv */
// Sentence framing: character count, prefix matching, kind and length at '*'.
// Depends on ngfe_pkg.

module ngfe_frame #(
    parameter int MAX_SENTENCE_LEN = 80
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            rx_char,
    output ngfe_pkg::frame_ctl_t  ctl
);

    localparam int CNT_W = $clog2(MAX_SENTENCE_LEN);
    localparam logic [CNT_W-1:0] LAST_POS   = CNT_W'(MAX_SENTENCE_LEN - 1);
    localparam logic [CNT_W-1:0] PREFIX_END = CNT_W'(ngfe_pkg::PREFIX_LEN);
    localparam logic [CNT_W-1:0] START_POS  = CNT_W'(ngfe_pkg::PREFIX_LEN - 1);
    localparam logic [7:0]       LEN_SAT    = 8'd127;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ngfe_pkg::KIND_NUM-1:0] prefix_reg, prefix_next;
    logic [ngfe_pkg::KIND_NUM-1:0] cand;
    logic                          is_star;
    logic                          take;
    logic [7:0]                    len_wide;
    ngfe_pkg::kind_t               kind;

    // Prefix candidates after this character
    always_comb
    begin
        cand = prefix_reg;
        if (count_reg < PREFIX_END)
        begin
            for (int k = 0; k < ngfe_pkg::KIND_NUM; k++)
            begin
                if (ngfe_pkg::kind_char(ngfe_pkg::KIND_TEXT[k], count_reg[2:0]) != rx_char)
                begin
                    cand[k] = 1'b0;
                end
            end
        end
    end

    // Kind decode at end of sentence, lowest candidate wins
    always_comb
    begin
        kind = ngfe_pkg::KIND_OTHER;
        if (count_reg >= PREFIX_END)
        begin
            for (int k = ngfe_pkg::KIND_NUM - 1; k >= 0; k--)
            begin
                if (prefix_reg[k])
                begin
                    kind = ngfe_pkg::kind_t'(3'(k + 1));
                end
            end
        end
    end

    // Characters past the length bound are dropped, '*' always taken
    assign is_star  = (rx_char == ngfe_pkg::CHAR_STAR);
    assign take     = fire && !is_star && (count_reg < LAST_POS);
    assign len_wide = 8'(count_reg) + 8'd1;

    always_comb
    begin
        count_next  = count_reg;
        prefix_next = prefix_reg;
        if (fire && is_star)
        begin
            count_next  = '0;
            prefix_next = '1;
        end
        else if (take)
        begin
            count_next  = count_reg + CNT_W'(1);
            prefix_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            prefix_reg <= '1;
        end
        else
        begin
            count_reg  <= count_next;
            prefix_reg <= prefix_next;
        end
    end

    // Control toward the field decoder and result stage
    always_comb
    begin
        ctl.start  = take && cand[0] && (count_reg == START_POS);
        ctl.parse  = take && cand[0] && (count_reg > START_POS);
        ctl.star   = fire && is_star;
        ctl.kind   = kind;
        ctl.length = (len_wide > LEN_SAT) ? 7'(LEN_SAT) : len_wide[6:0];
    end

endmodule

/* hdl/ngfe_gga_parse.sv */
// GGA field decoder: time, latitude and longitude digits into the pending fix.
// Depends on ngfe_pkg.

module ngfe_gga_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ngfe_pkg::frame_ctl_t  ctl,
    input  logic [7:0]            rx_char,
    output ngfe_pkg::fix_t        pending
);

    localparam logic [3:0] FIELD_TIME     = 4'd1;
    localparam logic [3:0] FIELD_LAT      = 4'd2;
    localparam logic [3:0] FIELD_LAT_HEMI = 4'd3;
    localparam logic [3:0] FIELD_LON      = 4'd4;
    localparam logic [3:0] FIELD_LON_HEMI = 4'd5;
    localparam logic [3:0] FIELD_MIN_OK   = 4'd11;
    localparam logic [3:0] FIELD_SAT      = 4'd15;
    localparam logic [3:0] POS_MIN        = 4'd2;
    localparam logic [3:0] POS_SEC        = 4'd4;
    localparam logic [3:0] POS_POINT      = 4'd6;
    localparam logic [3:0] POS_HUND_END   = 4'd9;
    localparam logic [3:0] FRAC_DIGITS    = 4'd4;
    localparam int         INT_DIGITS     = 5;

    logic [3:0]     field_reg, field_next;
    logic [3:0]     dpos_reg, dpos_next;
    logic           point_reg, point_next;
    logic [3:0]     int_dig_reg [INT_DIGITS];
    logic [3:0]     int_dig_next [INT_DIGITS];
    logic [3:0]     frac_dig_reg [4];
    logic [3:0]     frac_dig_next [4];
    logic [1:0]     flags_reg, flags_next;
    logic [6:0]     hund_reg, hund_next;
    ngfe_pkg::fix_t pend_reg, pend_next;

    logic           is_digit;
    logic [3:0]     dig;
    logic           pos_field;
    logic [3:0]     top_dig;
    logic [29:0]    field_value;
    logic [19:0]    tih_value;

    assign is_digit  = (rx_char >= ngfe_pkg::CHAR_ZERO) && (rx_char <= ngfe_pkg::CHAR_NINE);
    assign dig       = is_digit ? 4'(rx_char - ngfe_pkg::CHAR_ZERO) : 4'd0;
    assign pos_field = (field_reg == FIELD_LAT) || (field_reg == FIELD_LON);

    // Latitude keeps four integer digits, longitude five
    assign top_dig = (field_reg == FIELD_LAT) ? 4'd0 : int_dig_reg[4];

    // Degrees*600000 + minutes*10000 + minute fraction in 1/10000
    assign field_value = 30'(top_dig)         * 30'd60000000
                       + 30'(int_dig_reg[3])  * 30'd6000000
                       + 30'(int_dig_reg[2])  * 30'd600000
                       + 30'(int_dig_reg[1])  * 30'd100000
                       + 30'(int_dig_reg[0])  * 30'd10000
                       + 30'(frac_dig_reg[0]) * 30'd1000
                       + 30'(frac_dig_reg[1]) * 30'd100
                       + 30'(frac_dig_reg[2]) * 30'd10
                       + 30'(frac_dig_reg[3]);

    assign tih_value = 20'(pend_reg.minute) * 20'd6000
                     + 20'(pend_reg.second) * 20'd100
                     + 20'(hund_reg);

    // Per-character decode
    always_comb
    begin
        field_next    = field_reg;
        dpos_next     = dpos_reg;
        point_next    = point_reg;
        int_dig_next  = int_dig_reg;
        frac_dig_next = frac_dig_reg;
        flags_next    = flags_reg;
        hund_next     = hund_reg;
        pend_next     = pend_reg;

        if (ctl.start)
        begin
            // new GGA: clear all work state, fix reads as parse error until finished
            field_next    = '0;
            dpos_next     = '0;
            point_next    = 1'b0;
            int_dig_next  = '{default: '0};
            frac_dig_next = '{default: '0};
            flags_next    = '0;
            hund_next     = '0;
            pend_next     = '{status: ngfe_pkg::FIX_PARSE_ERR, default: '0};
        end
        else if (ctl.star)
        begin
            field_next = '0;
            dpos_next  = '0;
            point_next = 1'b0;
            if (ctl.kind == ngfe_pkg::KIND_GGA)
            begin
                if ((field_reg >= FIELD_MIN_OK) && (flags_reg == 2'b11))
                begin
                    pend_next.status = ngfe_pkg::FIX_VALID;
                    pend_next.tih    = tih_value;
                end
                else
                begin
                    pend_next = '{status: ngfe_pkg::FIX_PARSE_ERR, default: '0};
                end
            end
        end
        else if (ctl.parse)
        begin
            if (rx_char == ngfe_pkg::CHAR_COMMA)
            begin
                // close a position field that had a decimal point
                if (pos_field && point_reg)
                begin
                    if (field_reg == FIELD_LAT)
                    begin
                        pend_next.lat = 27'(field_value);
                        flags_next[0] = 1'b1;
                    end
                    else
                    begin
                        pend_next.lon = 31'(field_value);
                        flags_next[1] = 1'b1;
                    end
                end
                if (field_reg < FIELD_SAT)
                begin
                    field_next = field_reg + 4'd1;
                end
                dpos_next     = '0;
                point_next    = 1'b0;
                int_dig_next  = '{default: '0};
                frac_dig_next = '{default: '0};
            end
            else if (pos_field)
            begin
                if (!point_reg && (rx_char == ngfe_pkg::CHAR_POINT))
                begin
                    point_next = 1'b1;
                    dpos_next  = '0;
                end
                else if (!point_reg)
                begin
                    // shift in one integer digit, oldest drops out
                    for (int k = INT_DIGITS - 1; k > 0; k--)
                    begin
                        int_dig_next[k] = int_dig_reg[k-1];
                    end
                    int_dig_next[0] = dig;
                end
                else if (dpos_reg < FRAC_DIGITS)
                begin
                    frac_dig_next[dpos_reg[1:0]] = dig;
                    dpos_next = dpos_reg + 4'd1;
                end
            end
            else
            begin
                if (field_reg == FIELD_TIME)
                begin
                    if (dpos_reg < POS_MIN)
                    begin
                        pend_next.hour = 7'(pend_reg.hour * 7'd10 + 7'(dig));
                    end
                    else if (dpos_reg < POS_SEC)
                    begin
                        pend_next.minute = 7'(pend_reg.minute * 7'd10 + 7'(dig));
                    end
                    else if (dpos_reg < POS_POINT)
                    begin
                        pend_next.second = 7'(pend_reg.second * 7'd10 + 7'(dig));
                    end
                    else if (dpos_reg == POS_POINT)
                    begin
                        point_next = (rx_char == ngfe_pkg::CHAR_POINT);
                    end
                    else if ((dpos_reg < POS_HUND_END) && point_reg)
                    begin
                        hund_next = 7'(hund_reg * 7'd10 + 7'(dig));
                    end
                end
                else if ((field_reg == FIELD_LAT_HEMI) && (dpos_reg == 4'd0)
                         && (rx_char == ngfe_pkg::CHAR_SOUTH))
                begin
                    pend_next.lat = -pend_reg.lat;
                end
                else if ((field_reg == FIELD_LON_HEMI) && (dpos_reg == 4'd0)
                         && (rx_char == ngfe_pkg::CHAR_WEST))
                begin
                    pend_next.lon = -pend_reg.lon;
                end
                if (dpos_reg < FIELD_SAT)
                begin
                    dpos_next = dpos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg    <= '0;
            dpos_reg     <= '0;
            point_reg    <= 1'b0;
            int_dig_reg  <= '{default: '0};
            frac_dig_reg <= '{default: '0};
            flags_reg    <= '0;
            hund_reg     <= '0;
            pend_reg     <= ngfe_pkg::FIX_EMPTY;
        end
        else
        begin
            field_reg    <= field_next;
            dpos_reg     <= dpos_next;
            point_reg    <= point_next;
            int_dig_reg  <= int_dig_next;
            frac_dig_reg <= frac_dig_next;
            flags_reg    <= flags_next;
            hund_reg     <= hund_next;
            pend_reg     <= pend_next;
        end
    end

    assign pending = pend_reg;

endmodule

/* hdl/ngfe_result.sv */
// Committed fix register and the result output register with its stream handshake.
// Depends on ngfe_pkg.

module ngfe_result (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ngfe_pkg::frame_ctl_t  ctl,
    input  ngfe_pkg::fix_t        pending,
    output logic                  out_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [111:0]          m_axis_tdata,  // committed, fix_status, hour, minute, second,
                                                 // time_in_hour_centis, latitude, longitude,
                                                 // sentence_length, zero fill
    output logic [2:0]            m_axis_tuser   // sentence_kind
);

    ngfe_pkg::fix_t  committed_reg, committed_next;
    logic            out_valid_reg, out_valid_next;
    ngfe_pkg::kind_t out_kind_reg;
    logic            out_commit_reg;
    ngfe_pkg::fix_t  out_fix_reg;
    logic [6:0]      out_len_reg;
    logic            is_vtg;

    assign is_vtg   = (ctl.kind == ngfe_pkg::KIND_VTG);
    assign out_free = !out_valid_reg || m_axis_tready;

    // A VTG end commits the pending fix
    assign committed_next = (ctl.star && is_vtg) ? pending : committed_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.star)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= ngfe_pkg::FIX_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            committed_reg <= committed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded at each end of sentence
    always_ff @(posedge clk)
    begin
        if (ctl.star)
        begin
            out_kind_reg   <= ctl.kind;
            out_commit_reg <= is_vtg;
            out_fix_reg    <= committed_next;
            out_len_reg    <= ctl.length;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {3'b000, out_len_reg,
                            out_fix_reg.lon, out_fix_reg.lat, out_fix_reg.tih,
                            out_fix_reg.second, out_fix_reg.minute, out_fix_reg.hour,
                            out_fix_reg.status, out_commit_reg};

endmodule

/* hdl/nmea_gga_fix_extractor.sv */
// Top level of the NMEA GGA fix extractor: input register, framing, GGA decoder, result stage.
// Depends on ngfe_pkg, ngfe_frame, ngfe_gga_parse and ngfe_result.
//
// Usage: received ASCII characters enter on the s_axis stream, one per transfer.
// A sentence runs up to and including '*'; its first six characters select the
// kind. GGA sentences are decoded on the fly into a pending fix (UTC time,
// latitude and longitude in 1/600000 degree); the end of a VTG sentence
// commits the pending fix. Each '*' produces exactly one result transfer on
// m_axis with the kind in tuser and the committed fix and length in tdata;
// all other characters produce none. Characters beyond MAX_SENTENCE_LEN-1 in
// one sentence are dropped.
// Throughput: one character per cycle, except while a '*' waits for the output
// register. A '*' is first held in the input register; processing it loads the
// result register, and m_axis_tvalid is high from then on.
// Stalls: the input register keeps accepting while a result waits; only a '*'
// that meets an occupied output register waits, which holds s_axis_tready low.
// Reset clears the sentence state and both fixes to "no GGA yet" at once; the
// block accepts characters as soon as reset is released.

module nmea_gga_fix_extractor #(
    parameter int MAX_SENTENCE_LEN = 80
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // rx_char
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // committed, fix_status, hour, minute, second,
                                          // time_in_hour_centis, latitude, longitude,
                                          // sentence_length, zero fill
    output logic [2:0]    m_axis_tuser    // sentence_kind
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_char_reg;
    logic                 in_fire;
    logic                 proc_fire;
    logic                 is_star;
    logic                 out_free;
    ngfe_pkg::frame_ctl_t ctl;
    ngfe_pkg::fix_t       pending;

    // Input register; it moves on unless a '*' finds the output occupied
    assign is_star       = (in_char_reg == ngfe_pkg::CHAR_STAR);
    assign proc_fire     = in_valid_reg && (!is_star || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg <= s_axis_tdata;
        end
    end

    ngfe_frame #(
        .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (proc_fire),
        .rx_char (in_char_reg),
        .ctl     (ctl)
    );

    ngfe_gga_parse u_gga_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rx_char (in_char_reg),
        .pending (pending)
    );

    ngfe_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .pending       (pending),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A new result follows only from a processed '*'
    a_result_from_star: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(proc_fire && is_star)
    ) else $error("result appeared without an end of sentence");

    // The commit flag only ever goes with a VTG sentence
    a_commit_is_vtg: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == ngfe_pkg::KIND_VTG)
    ) else $error("commit flag on a sentence that is not VTG");

    // A fix that is not valid carries zero values
    a_invalid_fix_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:1] != ngfe_pkg::FIX_VALID))
            |-> (m_axis_tdata[101:3] == '0)
    ) else $error("invalid fix with nonzero values");

    // Input back-pressure only while a '*' waits for the output register
    a_stall_only_on_star: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && is_star && m_axis_tvalid && !m_axis_tready)
    ) else $error("input stalled without a pending end of sentence");

endmodule
